// ===== hdl/srw_pkg.sv =====
`timescale 1ns / 1ps

package srw_pkg;

	localparam int MAX_SEQ_NUM = 15;
	localparam int SEQ_MOD     = MAX_SEQ_NUM + 1;
	localparam int WIN         = SEQ_MOD / 2;
	localparam int SEQ_W       = 4;
	localparam int SLOT_W      = 3;
	localparam int CNT_W       = 4;
	localparam int TICK_W      = 16;
	localparam int REG_IDX_W   = 1;

	typedef logic [SEQ_W-1:0]  seq_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [TICK_W-1:0] tick_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// Input operations.
	localparam logic [2:0] OP_PACKET_READY = 3'd0;
	localparam logic [2:0] OP_PHYS_READY   = 3'd1;
	localparam logic [2:0] OP_FRAME_RX     = 3'd2;
	localparam logic [2:0] OP_DATA_TIMEOUT = 3'd3;
	localparam logic [2:0] OP_ACK_TIMEOUT  = 3'd4;

	// Result actions.
	localparam logic [2:0] ACT_SEND      = 3'd0;
	localparam logic [2:0] ACT_DELIVER   = 3'd1;
	localparam logic [2:0] ACT_STOP_DATA = 3'd2;
	localparam logic [2:0] ACT_START_ACK = 3'd3;
	localparam logic [2:0] ACT_STATUS    = 3'd4;

	// Frame kinds.
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_ACK  = 2'd1;
	localparam logic [1:0] KIND_NAK  = 2'd2;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_DATA_TIMEOUT = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_ACK_TIMEOUT  = 1'b1;

	localparam tick_t DATA_TICKS_RST = 16'd3712;
	localparam tick_t ACK_TICKS_RST  = 16'd263;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_PHYS,
		CMD_MARK,
		CMD_SEND_NEXT,
		CMD_SEND_NAK,
		CMD_SEND_ACKF,
		CMD_DELIVER,
		CMD_START_ACK,
		CMD_RESEND,
		CMD_STOP_ACKED,
		CMD_STOP_OLDEST,
		CMD_SEND_OLDEST,
		CMD_STATUS
	} cmd_t;

	typedef struct packed {
		logic       out_free;
		logic [2:0] op;
		logic       good;
		logic [1:0] kind;
		logic       lt_win;
		logic       out_nz;
		logic       nak_sent;
		logic       data_inwin;
		logic       arrived_hit;
		logic       deliver_more;
		logic       nak_resend_ok;
		logic       ack_more;
	} dp_status_t;

	function automatic seq_t seq_inc(input seq_t x);
		seq_inc = (x == seq_t'(MAX_SEQ_NUM)) ? '0 : seq_t'(x + 1'b1);
	endfunction

	function automatic seq_t seq_dec(input seq_t x);
		seq_dec = (x == '0) ? seq_t'(MAX_SEQ_NUM) : seq_t'(x - 1'b1);
	endfunction

	// True when b lies in the circular interval [a, c).
	function automatic logic in_window(input seq_t a, input seq_t b, input seq_t c);
		in_window = ((a <= b) && (b < c)) || (((a <= b) || (b < c)) && (c < a));
	endfunction

	function automatic slot_t slot_of(input seq_t x);
		slot_of = x[SLOT_W-1:0];
	endfunction

endpackage

// ===== hdl/srw_ctrl.sv =====
`timescale 1ns / 1ps

module srw_ctrl import srw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t status,
	output cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SEND_NEXT,
		S_NAK,
		S_SEND_ACKF,
		S_MARK,
		S_DELIVER,
		S_RESTART,
		S_NAK_RESEND,
		S_ACK_LOOP,
		S_STOP_OLDEST,
		S_SEND_OLDEST,
		S_STATUS
	} state_t;

	state_t state_q;
	state_t nxt;
	logic   restart_q;
	logic   set_restart;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		nxt         = state_q;
		cmd         = CMD_NONE;
		set_restart = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd = CMD_LOAD;
					nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (status.op)
					OP_PACKET_READY: nxt = status.lt_win ? S_SEND_NEXT : S_STATUS;
					OP_PHYS_READY: begin
						cmd = CMD_PHYS;
						nxt = S_STATUS;
					end
					OP_FRAME_RX: begin
						if (!status.good) begin
							nxt = status.nak_sent ? S_STATUS : S_NAK;
						end else if (status.kind == KIND_DATA) begin
							if (!status.data_inwin && !status.nak_sent) begin
								nxt = S_NAK;
							end else begin
								set_restart = 1'b1;
								nxt         = S_MARK;
							end
						end else if (status.kind == KIND_NAK) begin
							nxt = S_NAK_RESEND;
						end else begin
							nxt = S_ACK_LOOP;
						end
					end
					OP_DATA_TIMEOUT: nxt = status.out_nz ? S_STOP_OLDEST : S_STATUS;
					OP_ACK_TIMEOUT: nxt = S_SEND_ACKF;
					default: nxt = S_STATUS;
				endcase
			end
			S_SEND_NEXT: begin
				if (status.out_free) begin
					cmd = CMD_SEND_NEXT;
					nxt = S_STATUS;
				end
			end
			S_NAK: begin
				if (status.out_free) begin
					cmd = CMD_SEND_NAK;
					nxt = status.good ? S_MARK : S_STATUS;
				end
			end
			S_SEND_ACKF: begin
				if (status.out_free) begin
					cmd = CMD_SEND_ACKF;
					nxt = S_STATUS;
				end
			end
			S_MARK: begin
				if (status.data_inwin && !status.arrived_hit) begin
					cmd = CMD_MARK;
					nxt = S_DELIVER;
				end else begin
					nxt = S_RESTART;
				end
			end
			S_DELIVER: begin
				if (!status.deliver_more) begin
					nxt = S_RESTART;
				end else if (status.out_free) begin
					cmd         = CMD_DELIVER;
					set_restart = 1'b1;
				end
			end
			S_RESTART: begin
				// At most one ack timer start per event, after all deliveries.
				if (!restart_q) begin
					nxt = S_ACK_LOOP;
				end else if (status.out_free) begin
					cmd = CMD_START_ACK;
					nxt = S_ACK_LOOP;
				end
			end
			S_NAK_RESEND: begin
				if (!status.nak_resend_ok) begin
					nxt = S_ACK_LOOP;
				end else if (status.out_free) begin
					cmd = CMD_RESEND;
					nxt = S_ACK_LOOP;
				end
			end
			S_ACK_LOOP: begin
				if (!status.ack_more) begin
					nxt = S_STATUS;
				end else if (status.out_free) begin
					cmd = CMD_STOP_ACKED;
				end
			end
			S_STOP_OLDEST: begin
				if (status.out_free) begin
					cmd = CMD_STOP_OLDEST;
					nxt = S_SEND_OLDEST;
				end
			end
			S_SEND_OLDEST: begin
				if (status.out_free) begin
					cmd = CMD_SEND_OLDEST;
					nxt = S_STATUS;
				end
			end
			S_STATUS: begin
				if (status.out_free) begin
					cmd = CMD_STATUS;
					nxt = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			restart_q <= 1'b0;
		end else begin
			state_q <= nxt;
			if (cmd == CMD_LOAD) begin
				restart_q <= 1'b0;
			end else if (set_restart) begin
				restart_q <= 1'b1;
			end
		end
	end

endmodule

// ===== hdl/srw_dp.sv =====
`timescale 1ns / 1ps

module srw_dp import srw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  tick_t                cfg_data,
	input  logic [2:0]           operation,
	input  logic                 frame_good,
	input  logic [1:0]           frame_kind,
	input  seq_t                 frame_seq,
	input  seq_t                 piggy_ack,
	input  cmd_t                 cmd,
	output dp_status_t           status,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [2:0]           action,
	output logic [1:0]           send_kind,
	output seq_t                 send_seq,
	output seq_t                 send_ack,
	output slot_t                buffer_slot,
	output tick_t                timer_ticks,
	output logic                 network_enable,
	output logic                 last
);

	// Captured event.
	logic [2:0] op_q;
	logic       good_q;
	logic [1:0] kind_q;
	seq_t       seq_in_q;
	seq_t       ack_in_q;

	// Window state.
	seq_t           so_q;
	seq_t           sn_q;
	seq_t           re_q;
	seq_t           rl_q;
	cnt_t           outstanding_q;
	logic [WIN-1:0] arrived_q;
	logic           nak_sent_q;
	logic           phys_q;
	cnt_t           cnt_q;
	tick_t          data_ticks_q;
	tick_t          ack_ticks_q;

	// Output register.
	logic       out_valid_q;
	logic [2:0] action_q;
	logic [1:0] kind_o_q;
	seq_t       seq_o_q;
	seq_t       ack_o_q;
	slot_t      slot_o_q;
	tick_t      ticks_o_q;
	logic       en_o_q;
	logic       last_o_q;

	logic       emit;
	logic       out_free;
	logic       lt_win;
	seq_t       ack_plus;
	seq_t       re_prev;
	logic [2:0] n_action;
	logic [1:0] n_kind;
	seq_t       n_seq;
	seq_t       n_ack;
	slot_t      n_slot;
	tick_t      n_ticks;
	logic       n_en;
	logic       n_last;

	assign out_free = !out_valid_q || !out_stall;
	assign lt_win   = (outstanding_q < cnt_t'(WIN));
	assign ack_plus = seq_inc(ack_in_q);
	assign re_prev  = seq_dec(re_q);

	assign emit = (cmd == CMD_SEND_NEXT) || (cmd == CMD_SEND_NAK) || (cmd == CMD_SEND_ACKF) ||
		(cmd == CMD_DELIVER) || (cmd == CMD_START_ACK) || (cmd == CMD_RESEND) ||
		(cmd == CMD_STOP_ACKED) || (cmd == CMD_STOP_OLDEST) || (cmd == CMD_SEND_OLDEST) ||
		(cmd == CMD_STATUS);

	always_comb begin
		status.out_free      = out_free;
		status.op            = op_q;
		status.good          = good_q;
		status.kind          = kind_q;
		status.lt_win        = lt_win;
		status.out_nz        = (outstanding_q != '0);
		status.nak_sent      = nak_sent_q;
		status.data_inwin    = in_window(re_q, seq_in_q, rl_q);
		status.arrived_hit   = arrived_q[slot_of(seq_in_q)];
		status.deliver_more  = arrived_q[slot_of(re_q)];
		status.nak_resend_ok = in_window(so_q, ack_plus, sn_q);
		status.ack_more      = in_window(so_q, ack_in_q, sn_q) && (cnt_q < cnt_t'(WIN));
	end

	always_comb begin
		n_action = ACT_STATUS;
		n_kind   = KIND_DATA;
		n_seq    = '0;
		n_ack    = '0;
		n_slot   = '0;
		n_ticks  = '0;
		n_en     = 1'b0;
		n_last   = 1'b0;
		case (cmd)
			CMD_SEND_NEXT, CMD_SEND_OLDEST, CMD_RESEND: begin
				n_action = ACT_SEND;
				n_ack    = re_prev;
				n_ticks  = data_ticks_q;
				if (cmd == CMD_SEND_NEXT) begin
					n_seq = sn_q;
				end else if (cmd == CMD_SEND_OLDEST) begin
					n_seq = so_q;
				end else begin
					n_seq = ack_plus;
				end
				n_slot = slot_of(n_seq);
			end
			CMD_SEND_NAK: begin
				n_action = ACT_SEND;
				n_kind   = KIND_NAK;
				n_ack    = re_prev;
			end
			CMD_SEND_ACKF: begin
				n_action = ACT_SEND;
				n_kind   = KIND_ACK;
				n_ack    = re_prev;
			end
			CMD_DELIVER: begin
				n_action = ACT_DELIVER;
				n_slot   = slot_of(re_q);
			end
			CMD_START_ACK: begin
				n_action = ACT_START_ACK;
				n_ticks  = ack_ticks_q;
			end
			CMD_STOP_ACKED, CMD_STOP_OLDEST: begin
				n_action = ACT_STOP_DATA;
				n_slot   = slot_of(so_q);
			end
			CMD_STATUS: begin
				n_en   = lt_win && phys_q;
				n_last = 1'b1;
			end
			default: n_action = ACT_STATUS;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_LOAD) begin
			op_q     <= operation;
			good_q   <= frame_good;
			kind_q   <= frame_kind;
			seq_in_q <= frame_seq;
			ack_in_q <= piggy_ack;
		end
		if (emit) begin
			action_q  <= n_action;
			kind_o_q  <= n_kind;
			seq_o_q   <= n_seq;
			ack_o_q   <= n_ack;
			slot_o_q  <= n_slot;
			ticks_o_q <= n_ticks;
			en_o_q    <= n_en;
			last_o_q  <= n_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			so_q          <= '0;
			sn_q          <= '0;
			re_q          <= '0;
			rl_q          <= seq_t'(WIN);
			outstanding_q <= '0;
			arrived_q     <= '0;
			nak_sent_q    <= 1'b0;
			phys_q        <= 1'b0;
			cnt_q         <= '0;
			data_ticks_q  <= DATA_TICKS_RST;
			ack_ticks_q   <= ACK_TICKS_RST;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_DATA_TIMEOUT: data_ticks_q <= cfg_data;
					REG_ACK_TIMEOUT: ack_ticks_q <= cfg_data;
					default: ;
				endcase
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (cmd)
				CMD_LOAD: cnt_q <= '0;
				CMD_PHYS: phys_q <= 1'b1;
				CMD_MARK: arrived_q[slot_of(seq_in_q)] <= 1'b1;
				CMD_SEND_NEXT: begin
					outstanding_q <= cnt_t'(outstanding_q + 1'b1);
					sn_q          <= seq_inc(sn_q);
					phys_q        <= 1'b0;
				end
				CMD_SEND_NAK: begin
					nak_sent_q <= 1'b1;
					phys_q     <= 1'b0;
				end
				CMD_SEND_ACKF, CMD_SEND_OLDEST, CMD_RESEND: phys_q <= 1'b0;
				CMD_DELIVER: begin
					arrived_q[slot_of(re_q)] <= 1'b0;
					nak_sent_q               <= 1'b0;
					re_q                     <= seq_inc(re_q);
					rl_q                     <= seq_inc(rl_q);
				end
				CMD_STOP_ACKED: begin
					if (outstanding_q != '0) begin
						outstanding_q <= cnt_t'(outstanding_q - 1'b1);
					end
					so_q  <= seq_inc(so_q);
					cnt_q <= cnt_t'(cnt_q + 1'b1);
				end
				default: ;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign action         = action_q;
	assign send_kind      = kind_o_q;
	assign send_seq       = seq_o_q;
	assign send_ack       = ack_o_q;
	assign buffer_slot    = slot_o_q;
	assign timer_ticks    = ticks_o_q;
	assign network_enable = en_o_q;
	assign last           = last_o_q;

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result written into an occupied output register");

	a_outstanding_cap: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= cnt_t'(WIN))
		else $error("outstanding count above window size");

	a_send_span: assert property (@(posedge clk) disable iff (!arst_n)
		seq_t'(sn_q - so_q) == seq_t'(outstanding_q))
		else $error("send window span disagrees with outstanding count");

	a_recv_span: assert property (@(posedge clk) disable iff (!arst_n)
		rl_q == seq_t'(re_q + seq_t'(WIN)))
		else $error("receive window edges out of step");

endmodule

// ===== hdl/selective_repeat_arq_window_top.sv =====
// Selective-repeat window controller: one event in, a burst of result beats out, status last.
// Each event is captured, decoded in a dispatch state, and its results are written one by one
// into the output register while out_stall is low, the status beat closing the burst.
// One event is handled at a time; a stalled output register holds the controller, and the next
// event is taken once the status beat is written. Reset clears window edges (the receive
// limit goes to WIN), outstanding count, arrived map and flags; timeouts go to 3712/263.
`timescale 1ns / 1ps

module selective_repeat_arq_window_top import srw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           operation,
	input  logic                 frame_good,
	input  logic [1:0]           frame_kind,
	input  logic [3:0]           frame_seq,
	input  logic [3:0]           piggy_ack,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           action,
	output logic [1:0]           send_kind,
	output logic [3:0]           send_seq,
	output logic [3:0]           send_ack,
	output logic [2:0]           buffer_slot,
	output logic [15:0]          timer_ticks,
	output logic                 network_enable,
	output logic                 last
);

	cmd_t       cmd;
	dp_status_t status;

	srw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	srw_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.operation      (operation),
		.frame_good     (frame_good),
		.frame_kind     (frame_kind),
		.frame_seq      (frame_seq),
		.piggy_ack      (piggy_ack),
		.cmd            (cmd),
		.status         (status),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.action         (action),
		.send_kind      (send_kind),
		.send_seq       (send_seq),
		.send_ack       (send_ack),
		.buffer_slot    (buffer_slot),
		.timer_ticks    (timer_ticks),
		.network_enable (network_enable),
		.last           (last)
	);

endmodule
